FILE: design/dqu_pkg.sv
// Shared types and constants for the double-ended queue unit.
// No dependencies; imported by the controller, the datapath and the top level.
package dqu_pkg;

  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int FILL_W      = 5;
  localparam int DEPTH_DEF   = 16;
  localparam int ELEM_W_DEF  = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] element_in;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]   element_out;
    logic                element_valid;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill_count;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } dqu_state_t;

  typedef struct packed {
    logic capture;  // latch the input word
    logic exec;     // update pointers, access slot memory
    logic load;     // fill the output register
  } dqu_cmd_t;

endpackage

FILE: design/dqu_ctrl.sv
// Controller for the double-ended queue unit: sequences capture, execute and load.
// Depends on dqu_pkg.
module dqu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output dqu_pkg::dqu_cmd_t cmd
);
  import dqu_pkg::*;

  dqu_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_LOAD;
      S_LOAD: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == S_IDLE);
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.exec    = (state_r == S_EXEC);
    cmd.load    = (state_r == S_LOAD) && (!out_valid_r || out_ready);
  end

  // hold the result until taken; a fresh load replaces a word taken this cycle
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EXEC)
    else $error("accepted word did not move to execute");

  a_exec_load : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_LOAD)
    else $error("execute not followed by load");

  a_load_valid : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r && state_r == S_IDLE)
    else $error("load did not present a result");

endmodule

FILE: design/dqu_datapath.sv
// Datapath for the double-ended queue unit: slot memory, head and count, output register.
// Depends on dqu_pkg; driven by dqu_ctrl commands.
module dqu_datapath #(
  parameter int DEPTH  = dqu_pkg::DEPTH_DEF,
  parameter int ELEM_W = dqu_pkg::ELEM_W_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dqu_pkg::dqu_cmd_t cmd,
  input  dqu_pkg::in_word_t in_word,
  output dqu_pkg::out_word_t out_word
);
  import dqu_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SUM_W = AW + 2;
  localparam int SW    = (ELEM_W < DATA_W) ? ELEM_W : DATA_W;

  logic [SW-1:0]       mem [DEPTH];
  logic [OP_W-1:0]     op_r;
  logic [SW-1:0]       elem_r;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [SW-1:0]       rd_data_r;
  logic                res_valid_r;
  logic [STATUS_W-1:0] res_status_r;
  out_word_t           out_r;

  logic [AW-1:0]       addr;
  logic                wr_en;
  logic                pop_ok;
  logic [STATUS_W-1:0] status;
  logic                full, empty;

  // sum is below twice the depth, so one subtract wraps it
  function automatic logic [AW-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] w;
    w = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
    return w[AW-1:0];
  endfunction

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    addr      = head_r;
    wr_en     = 1'b0;
    pop_ok    = 1'b0;
    status    = STAT_OK;
    case (op_r)
      OP_PUSH_BACK: begin
        if (full) begin
          status = STAT_FULL;
        end else begin
          addr      = wrap(SUM_W'(head_r) + SUM_W'(count_r));
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status = STAT_FULL;
        end else begin
          head_nxt  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
          addr      = head_nxt;
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status = STAT_EMPTY;
        end else begin
          addr      = wrap(SUM_W'(head_r) + SUM_W'(count_r) - SUM_W'(1));
          pop_ok    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = STAT_EMPTY;
        end else begin
          addr      = head_r;
          pop_ok    = 1'b1;
          head_nxt  = wrap(SUM_W'(head_r) + SUM_W'(1));
          count_nxt = count_r - 1'b1;
        end
      end
      OP_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_word.operation;
      elem_r <= SW'(in_word.element_in);
    end
    if (cmd.exec) begin
      res_valid_r  <= pop_ok;
      res_status_r <= status;
    end
  end

  // single-port slot memory with registered read
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) mem[addr] <= elem_r;
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.element_out   <= res_valid_r ? DATA_W'(rd_data_r) : '0;
      out_r.element_valid <= res_valid_r;
      out_r.status        <= res_status_r;
      out_r.fill_count    <= FILL_W'(count_r);
    end
  end

  assign out_word = out_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH) && head_r <= AW'(DEPTH - 1))
    else $error("head or count out of range");

  a_clear : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_r == OP_CLEAR |=> count_r == '0 && head_r == '0)
    else $error("clear left elements behind");

  a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && pop_ok |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not shrink the queue by one");

endmodule

FILE: design/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: joins dqu_ctrl and dqu_datapath.
// Depends on dqu_pkg.
//
// Each accepted word (push back, push front, pop back, pop front or clear)
// yields exactly one result word. From acceptance to result a word passes
// through capture, one access to the single-port slot memory (whose read is
// registered), and a load of the output register. The next word is accepted
// once the previous one has reached the output register, even if that result
// is still waiting, so the unit works on one word at a time; a stalled output
// holds the following word in the load step. Pushes to a full queue are
// dropped and flagged, pops from an empty queue are flagged and return zero.
// fill_count carries the low 5 bits of the element count.
module double_ended_queue_unit #(
  parameter int DEPTH  = dqu_pkg::DEPTH_DEF,
  parameter int ELEM_W = dqu_pkg::ELEM_W_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dqu_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dqu_pkg::out_word_t out_data
);
  import dqu_pkg::*;

  dqu_cmd_t cmd;

  dqu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dqu_datapath #(
    .DEPTH  (DEPTH),
    .ELEM_W (ELEM_W)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_data),
    .out_word (out_data)
  );

endmodule
